>>> rtl/bfp_pkg.sv
// Package: shared types and constants for the bit field packer.
`timescale 1ns / 1ps
package bfp_pkg;

   typedef enum logic [1:0] {
      WIDTH_1  = 2'd0,
      WIDTH_6  = 2'd1,
      WIDTH_8  = 2'd2,
      WIDTH_16 = 2'd3
   } width_code_type;

   localparam logic ACTION_APPEND = 1'b0;
   localparam logic ACTION_FLUSH  = 1'b1;

   localparam int PEND_WIDTH = 7;
   localparam int ACC_WIDTH  = 23;

   typedef struct packed {
      logic [1:0] n_bytes;
      logic [7:0] byte0;
      logic [7:0] byte1;
   } pack_result_type;

endpackage

>>> rtl/bfp_pack_core.sv
// Pending bit state and the single-pass packing logic.
`timescale 1ns / 1ps
module bfp_pack_core
   import bfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic            action,
   input  logic [1:0]      width_code,
   input  logic [15:0]     field_value,
   output pack_result_type result
);

   logic [PEND_WIDTH-1:0] pend_ff, pend_in;
   logic [2:0]            cnt_ff, cnt_in;

   logic [15:0]          bits;
   logic [4:0]           w;
   logic [ACC_WIDTH-1:0] acc;
   logic [4:0]           total;
   logic [2:0]           new_cnt;
   logic [7:0]           flush_byte;

   always_comb begin
      unique case (width_code_type'(width_code))
         WIDTH_1: begin
            bits = {15'd0, field_value[0]};
            w    = 5'd1;
         end
         WIDTH_6: begin
            bits = {10'd0, field_value[5:0]};
            w    = 5'd6;
         end
         WIDTH_8: begin
            bits = {8'd0, field_value[7:0]};
            w    = 5'd8;
         end
         WIDTH_16: begin
            bits = {field_value[7:0], field_value[15:8]};
            w    = 5'd16;
         end
         default: begin
            bits = 16'd0;
            w    = 5'd0;
         end
      endcase
   end

   always_comb begin
      acc        = ({16'd0, pend_ff} << w) | {7'd0, bits};
      total      = {2'd0, cnt_ff} + w;
      new_cnt    = total[2:0];
      flush_byte = {pend_ff, 1'b0} << (3'd7 - cnt_ff);

      result.byte0 = 8'(acc >> (total - 5'd8));
      result.byte1 = 8'(acc >> (total - 5'd16));
      if (action == ACTION_FLUSH) begin
         result.n_bytes = (cnt_ff != 3'd0) ? 2'd1 : 2'd0;
         result.byte0   = flush_byte;
         pend_in        = '0;
         cnt_in         = 3'd0;
      end else begin
         if (total >= 5'd16) begin
            result.n_bytes = 2'd2;
         end else if (total >= 5'd8) begin
            result.n_bytes = 2'd1;
         end else begin
            result.n_bytes = 2'd0;
         end
         cnt_in  = new_cnt;
         pend_in = acc[PEND_WIDTH-1:0] & (7'h7f >> (3'd7 - new_cnt));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         cnt_ff  <= 3'd0;
      end else if (fire) begin
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

>>> rtl/bit_field_packer.sv
// Top level: packs 1/6/8/16-bit fields MSB first into a byte stream; a 16-bit field goes out low byte first.
// The first byte of an item is offered in the cycle after its transfer.
// Throughput: one item per cycle while items yield at most one byte and rsp_ready is high;
// an item that yields two bytes blocks new items until its first byte leaves the two-entry output queue.
// Reset clears the pending bits, their count and the output queue.
`timescale 1ns / 1ps
module bit_field_packer
   import bfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [1:0]  req_width_code,
   input  logic [15:0] req_field_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_last
);

   pack_result_type result;
   logic            fire;
   logic            pop;

   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] head_byte_ff, head_byte_in;
   logic [7:0] tail_byte_ff, tail_byte_in;

   assign pop       = rsp_valid & rsp_ready;
   assign req_ready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);
   assign fire      = req_valid & req_ready;

   bfp_pack_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .action      (req_action),
      .width_code  (req_width_code),
      .field_value (req_field_value),
      .result      (result)
   );

   always_comb begin
      cnt_in       = cnt_ff;
      head_byte_in = head_byte_ff;
      tail_byte_in = tail_byte_ff;
      if (fire) begin
         cnt_in       = result.n_bytes;
         head_byte_in = result.byte0;
         tail_byte_in = result.byte1;
      end else if (pop) begin
         cnt_in       = cnt_ff - 2'd1;
         head_byte_in = tail_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_byte_ff <= head_byte_in;
      tail_byte_ff <= tail_byte_in;
   end

   assign rsp_valid    = (cnt_ff != 2'd0);
   assign rsp_out_byte = head_byte_ff;
   assign rsp_is_last  = (cnt_ff == 2'd1);

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue count out of range");

   a_two_bytes: assert property (@(posedge clock) disable iff (reset)
      fire && result.n_bytes == 2'd2 |=> cnt_ff == 2'd2 && !rsp_is_last)
      else $error("two-byte item not queued as two transfers");

   a_no_bytes: assert property (@(posedge clock) disable iff (reset)
      fire && result.n_bytes == 2'd0 |=> !rsp_valid)
      else $error("item without bytes produced a transfer");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && rsp_ready |=>
         cnt_ff == 2'd1 && head_byte_ff == $past(tail_byte_ff))
      else $error("queue did not advance to second byte");
`endif

endmodule
